>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is high.
`define IHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define IHM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ihm_pkg.sv
`timescale 1ns / 1ps

package ihm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int NUM_SAMPLES     = 7;
  localparam int NUM_GRAV        = 3;
  localparam int CTL_BITS        = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int M_TDATA_W       = 16;

  // opcodes
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // chip id check results
  localparam logic [1:0] ID_OK    = 2'd0;
  localparam logic [1:0] ID_BUS   = 2'd1;
  localparam logic [1:0] ID_WRONG = 2'd2;

  // device states
  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_DISC  = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  // return status
  localparam logic [2:0] RS_OK        = 3'd0;
  localparam logic [2:0] RS_NOT_READY = 3'd1;
  localparam logic [2:0] RS_TIMEOUT   = 3'd2;
  localparam logic [2:0] RS_BAD_ID    = 3'd3;
  localparam logic [2:0] RS_HW_ERROR  = 3'd4;

  // error codes
  localparam logic [2:0] ER_NONE   = 3'd0;
  localparam logic [2:0] ER_COMM   = 3'd1;
  localparam logic [2:0] ER_BAD_ID = 3'd2;
  localparam logic [2:0] ER_MODE   = 3'd3;
  localparam logic [2:0] ER_SANITY = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMM_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SANITY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_MAX     = 3'd5;

  // register reset values
  localparam logic [3:0]  RST_COMM_LIMIT   = 4'd3;
  localparam logic [7:0]  RST_SANITY_LIMIT = 8'd10;
  localparam logic [31:0] RST_GRAV_MIN     = 32'd374338;
  localparam logic [31:0] RST_GRAV_MAX     = 32'd1757293;
  localparam logic [31:0] RST_QUAT_MIN     = 32'd131533373;
  localparam logic [31:0] RST_QUAT_MAX     = 32'd453655921;

  localparam logic [3:0] COMM_CNT_MAX   = 4'hF;
  localparam logic [7:0] SANITY_CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [3:0]  comm_fail_limit;
    logic [7:0]  sanity_fail_limit;
    logic [31:0] grav_min_sq;
    logic [31:0] grav_max_sq;
    logic [31:0] quat_min_sq;
    logic [31:0] quat_max_sq;
  } cfg_t;

  // classified word passed from front to back
  typedef struct packed {
    logic       opcode;
    logic [1:0] id_result;
    logic       config_mode_ok;
    logic       fusion_mode_ok;
    logic       read_ok;
    logic       win_fail;
  } item_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       sample_bad;
    logic [2:0] error_code;
    logic [1:0] device_state_out;
    logic [2:0] return_status;
  } res_t;

endpackage

>>> rtl/imu_health_monitor_top.sv
`timescale 1ns / 1ps

// IMU health monitor.
// Input stream: one word per init or poll event. s_tuser is the opcode
// (0 init, 1 poll); s_tdata carries the bus results and one raw gravity
// and quaternion sample. Output stream: one word per input word, in order,
// with status, device state, stored error and the bad sample flag.
// Config: write cfg_data to register cfg_index while cfg_we is high; only
// write while no word is in flight.
// A result passes the square stage, the queue, then the state update into
// the output register. Throughput is one word per cycle while m_tready
// stays high; the device state update is a registered loop in the back end.
// A four-word queue separates the sample math from the state update, so a
// stalled m_tready fills the queue and then drops s_tready; nothing is lost.
// Reset clears the queue, the output valid flag, the counters and puts the
// device in the init state with registers at their defaults.
module imu_health_monitor_top #(
  parameter int SAMPLE_BITS = ihm_pkg::SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = ihm_pkg::QUEUE_DEPTH_DEF,
  localparam int IN_W       = ihm_pkg::CTL_BITS + ihm_pkg::NUM_SAMPLES * SAMPLE_BITS,
  localparam int S_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // id_result, config_mode_ok, fusion_mode_ok, read_ok, grav_x, grav_y,
  // grav_z, quat_w, quat_x, quat_y, quat_z
  input  logic [S_TDATA_W-1:0]              s_tdata,
  // opcode
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // return_status, device_state_out, error_code, sample_bad
  output logic [ihm_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                              cfg_we,
  input  logic [ihm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ihm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ihm_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  full;
  logic  pop;
  item_t head;
  logic  empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comm_fail_limit   <= RST_COMM_LIMIT;
      cfg.sanity_fail_limit <= RST_SANITY_LIMIT;
      cfg.grav_min_sq       <= RST_GRAV_MIN;
      cfg.grav_max_sq       <= RST_GRAV_MAX;
      cfg.quat_min_sq       <= RST_QUAT_MIN;
      cfg.quat_max_sq       <= RST_QUAT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMM_LIMIT:   cfg.comm_fail_limit   <= cfg_data[3:0];
        REG_SANITY_LIMIT: cfg.sanity_fail_limit <= cfg_data[7:0];
        REG_GRAV_MIN:     cfg.grav_min_sq       <= cfg_data;
        REG_GRAV_MAX:     cfg.grav_max_sq       <= cfg_data;
        REG_QUAT_MIN:     cfg.quat_min_sq       <= cfg_data;
        REG_QUAT_MAX:     cfg.quat_max_sq       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ihm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .S_TDATA_W   (S_TDATA_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  ihm_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (push_item),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  ihm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .item     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/ihm_front.sv
`timescale 1ns / 1ps

module ihm_front #(
  parameter int SAMPLE_BITS = ihm_pkg::SAMPLE_BITS_DEF,
  parameter int S_TDATA_W   = 120
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ihm_pkg::cfg_t        cfg,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 push,
  output ihm_pkg::item_t       push_item,
  input  logic                 full
);
  import ihm_pkg::*;

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W = (SQ_W + 2 > 33) ? SQ_W + 2 : 33;

  logic signed [SAMPLE_BITS-1:0] smp  [NUM_SAMPLES];
  logic signed [SQ_W-1:0]        prod [NUM_SAMPLES];
  logic        [SQ_W-1:0]        sq   [NUM_SAMPLES];
  logic                          s1_valid;
  logic                          s1_opcode;
  logic [1:0]                    s1_id;
  logic                          s1_cfg_ok;
  logic                          s1_fus_ok;
  logic                          s1_rd_ok;
  logic [SUM_W-1:0]              gsum;
  logic [SUM_W-1:0]              qsum;

  always_comb begin
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      smp[k]  = s_tdata[CTL_BITS + k*SAMPLE_BITS +: SAMPLE_BITS];
      prod[k] = SQ_W'(smp[k]) * SQ_W'(smp[k]);
    end
  end

  assign s_tready = !s1_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  // squares registered, sums and window compare after
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_opcode <= s_tuser;
      s1_id     <= s_tdata[1:0];
      s1_cfg_ok <= s_tdata[2];
      s1_fus_ok <= s_tdata[3];
      s1_rd_ok  <= s_tdata[4];
      for (int k = 0; k < NUM_SAMPLES; k++) begin
        sq[k] <= prod[k];
      end
    end
  end

  always_comb begin
    gsum = '0;
    qsum = '0;
    for (int k = 0; k < NUM_GRAV; k++) begin
      gsum = gsum + SUM_W'(sq[k]);
    end
    for (int k = NUM_GRAV; k < NUM_SAMPLES; k++) begin
      qsum = qsum + SUM_W'(sq[k]);
    end
  end

  assign push                     = s1_valid && !full;
  assign push_item.opcode         = s1_opcode;
  assign push_item.id_result      = s1_id;
  assign push_item.config_mode_ok = s1_cfg_ok;
  assign push_item.fusion_mode_ok = s1_fus_ok;
  assign push_item.read_ok        = s1_rd_ok;
  assign push_item.win_fail       = (gsum < SUM_W'(cfg.grav_min_sq)) ||
                                    (gsum > SUM_W'(cfg.grav_max_sq)) ||
                                    (qsum < SUM_W'(cfg.quat_min_sq)) ||
                                    (qsum > SUM_W'(cfg.quat_max_sq));

endmodule

>>> rtl/ihm_fifo.sv
`timescale 1ns / 1ps

module ihm_fifo #(
  parameter int WIDTH = 7,
  parameter int DEPTH = ihm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ihm_back.sv
`timescale 1ns / 1ps

module ihm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  ihm_pkg::cfg_t                     cfg,
  input  logic                              empty,
  input  ihm_pkg::item_t                    item,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ihm_pkg::M_TDATA_W-1:0]     m_tdata
);
  import ihm_pkg::*;

  logic [1:0] dev_state;
  logic [1:0] dev_state_next;
  logic [2:0] err;
  logic [2:0] err_next;
  logic [3:0] comm_cnt;
  logic [3:0] comm_cnt_next;
  logic [7:0] san_cnt;
  logic [7:0] san_cnt_next;
  logic [3:0] comm_base;
  logic [3:0] comm_inc;
  logic [7:0] san_inc;
  res_t       res;
  res_t       res_next;

  assign pop = !empty && (!m_tvalid || m_tready);

  // bad id check keeps the count, good id check clears it before the read
  assign comm_base = (item.id_result != ID_OK) ? comm_cnt : 4'd0;
  assign comm_inc  = (comm_base == COMM_CNT_MAX) ? comm_base : comm_base + 4'd1;
  assign san_inc   = (san_cnt == SANITY_CNT_MAX) ? san_cnt : san_cnt + 8'd1;

  always_comb begin
    dev_state_next = dev_state;
    err_next       = err;
    comm_cnt_next  = comm_cnt;
    san_cnt_next   = san_cnt;
    res_next       = '0;
    res_next.return_status = RS_OK;
    if (item.opcode == OP_INIT) begin
      comm_cnt_next = 4'd0;
      san_cnt_next  = 8'd0;
      case (item.id_result)
        ID_OK: begin
          if (item.config_mode_ok && item.fusion_mode_ok) begin
            dev_state_next         = ST_READY;
            err_next               = ER_NONE;
            res_next.return_status = RS_OK;
          end else begin
            dev_state_next         = ST_INIT;
            err_next               = ER_MODE;
            res_next.return_status = RS_HW_ERROR;
          end
        end
        ID_WRONG: begin
          dev_state_next         = ST_ERROR;
          err_next               = ER_BAD_ID;
          res_next.return_status = RS_BAD_ID;
        end
        default: begin
          dev_state_next         = ST_DISC;
          err_next               = ER_COMM;
          res_next.return_status = RS_TIMEOUT;
        end
      endcase
    end else if (dev_state != ST_READY) begin
      res_next.return_status = RS_NOT_READY;
    end else if ((item.id_result != ID_OK) || !item.read_ok) begin
      if (comm_inc >= cfg.comm_fail_limit) begin
        dev_state_next         = ST_DISC;
        comm_cnt_next          = 4'd0;
        err_next               = ER_COMM;
        res_next.return_status = RS_TIMEOUT;
      end else begin
        comm_cnt_next = comm_inc;
      end
    end else begin
      comm_cnt_next = 4'd0;
      if (item.win_fail) begin
        res_next.sample_bad = 1'b1;
        if (san_inc >= cfg.sanity_fail_limit) begin
          dev_state_next         = ST_ERROR;
          san_cnt_next           = 8'd0;
          err_next               = ER_SANITY;
          res_next.return_status = RS_HW_ERROR;
        end else begin
          san_cnt_next = san_inc;
        end
      end else begin
        san_cnt_next = 8'd0;
      end
    end
    res_next.device_state_out = dev_state_next;
    res_next.error_code       = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_state <= ST_INIT;
      err       <= ER_NONE;
      comm_cnt  <= 4'd0;
      san_cnt   <= 8'd0;
      m_tvalid  <= 1'b0;
    end else begin
      if (pop) begin
        dev_state <= dev_state_next;
        err       <= err_next;
        comm_cnt  <= comm_cnt_next;
        san_cnt   <= san_cnt_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

  assign m_tdata = res;

endmodule

>>> rtl/ihm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ihm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ihm_pkg::M_TDATA_W-1:0] m_tdata
);
  import ihm_pkg::*;

  `IHM_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "output valid right after reset")
  `IHM_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")
  `IHM_ASSERT(a_ready_no_err, m_tvalid && m_tdata[4:3] == ST_READY |-> m_tdata[7:5] == ER_NONE, "ready with error")
  `IHM_ASSERT(a_not_ready, m_tvalid && m_tdata[2:0] == RS_NOT_READY |-> m_tdata[4:3] != ST_READY, "not ready while ready")
  `IHM_ASSERT(a_disc_comm, m_tvalid && m_tdata[4:3] == ST_DISC |-> m_tdata[7:5] == ER_COMM, "disconnected without comm fail")

endmodule

bind imu_health_monitor_top ihm_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
